// ===== hw/rtl/ids_pkg.sv =====
// ----------------------------------------------------------------------------
// ids_pkg: shared types and constants for the ignition dwell scheduler
// Mode codes, register indexes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package ids_pkg;

   // default parameter values
   localparam int TICK_BITS_DEFAULT           = 32;
   localparam int ANGLE_FRACTION_BITS_DEFAULT = 6;

   // fixed field widths
   localparam int TPS_BITS       = 32;  // ticks per second register
   localparam int RATE_BITS      = 20;  // position_rate, degrees per second
   localparam int CYC_DEG_BITS   = 10;  // holds 720
   localparam int DELTA_MAG_BITS = 17;  // |tdc - advance - position| < 2^17
   localparam int REQ_DATA_BITS  = 200;
   localparam int RSP_DATA_BITS  = 72;

   localparam logic [CYC_DEG_BITS-1:0] CYCLE_DEG_SEQ  = 10'd720;
   localparam logic [CYC_DEG_BITS-1:0] CYCLE_DEG_WASTE = 10'd360;

   localparam logic [TPS_BITS-1:0] TPS_RESET = 32'd1000000;

   // item kinds
   localparam logic [1:0] MODE_SCHEDULE     = 2'd0;
   localparam logic [1:0] MODE_DWELL_FIRED  = 2'd1;
   localparam logic [1:0] MODE_IGNITE_FIRED = 2'd2;

   // register indexes
   localparam logic CSR_TDC_ANGLE        = 1'b0;
   localparam logic CSR_TICKS_PER_SECOND = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,   // waiting for a beat
      ST_DEC,    // decode kind, start angle modulo
      ST_MOD,    // angle modulo cycle
      ST_DIVC,   // cycle ticks division
      ST_DIVA,   // angle ticks division
      ST_CHK,    // history check
      ST_AL1,    // re-anchor dwell history past now - cycle
      ST_ADV,    // align to previous dwell
      ST_AL2,    // alignment division
      ST_FIN,    // dwell and spark ticks, clamp window
      ST_FIN2,   // clamp and arm
      ST_EMIT    // load result register
   } state_type;

endpackage

// ===== hw/rtl/ignition_dwell_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// ignition_dwell_scheduler_top: ignition coil dwell and spark scheduler
// Turns crank angle to TDC into timer ticks, aligns the dwell start to the
// previous dwell and arms dwell/spark timers; handles fired timer events.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  req_tdata (item fields), req_tuser (mode)
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata (ticks and armed/coil flags)
// csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// Flow: timer events, mode 3 and unsynced requests go from decode straight
// to the result. A schedule request runs the angle modulo, cycle ticks and
// angle ticks divisions, plus up to two alignment divisions, before the
// result. The shared restoring divider, one quotient bit per cycle, does all
// of these divisions. One item is in work at a time.
// Reset: synchronous, clears all scheduler state and config to reset values.
// Stalls: a finished result waits in the output register while the next beat
// is accepted; the sequencer holds before loading it until that register frees.
//
module ignition_dwell_scheduler_top #(
   parameter int TICK_BITS           = ids_pkg::TICK_BITS_DEFAULT,
   parameter int ANGLE_FRACTION_BITS = ids_pkg::ANGLE_FRACTION_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // synced, enable, sequential, position[15:0], position_rate[19:0],
   // calculated_tick[31:0], current_tick[31:0], dwell_ticks[23:0],
   // advance[14:0], max_deviation_ticks[23:0], event_tick[31:0], 2 pad bits
   input  logic [ids_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]  req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // dwell_at[31:0], ignite_at[31:0], dwell_armed, ignite_armed, coil_on,
   // 5 pad bits
   output logic [ids_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int TW     = TICK_BITS;
   localparam int AFB    = ANGLE_FRACTION_BITS;
   localparam int ANG_W  = ids_pkg::CYC_DEG_BITS + AFB;
   localparam int MUL_W  = ids_pkg::TPS_BITS + ANG_W;
   localparam int NUM_W  = (TW > MUL_W) ? TW : MUL_W;
   localparam int DEN_W  = (TW > ids_pkg::RATE_BITS + AFB) ? TW : ids_pkg::RATE_BITS + AFB;
   localparam int CNT_W  = $clog2(NUM_W + 1);
   localparam int K_MOD  = ids_pkg::DELTA_MAG_BITS;
   localparam int K_CYC  = ids_pkg::TPS_BITS + ids_pkg::CYC_DEG_BITS;
   localparam int K_ANG  = MUL_W;
   localparam int K_TICK = TW;
   localparam logic [TW-1:0] CYCLE_MAX = {1'b0, {(TW-1){1'b1}}};

   // wraparound tick compare: a before b
   function automatic logic t_less(input logic [TW-1:0] a, input logic [TW-1:0] b);
      logic [TW-1:0] d;
      d = a - b;
      return d[TW-1];
   endfunction

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   ids_pkg::state_type state_ff, state_in;

   logic [15:0]       tdc_ff, tdc_in;
   logic [31:0]       tps_ff, tps_in;

   logic [TW-1:0]     last_ff, last_in;
   logic              dwelling_ff, dwelling_in;
   logic              prev_seq_ff, prev_seq_in;
   logic              dp_ff, dp_in;
   logic              ip_ff, ip_in;
   logic [TW-1:0]     fired_ff, fired_in;

   logic [ids_pkg::REQ_DATA_BITS-1:0] item_ff;
   logic [1:0]        kind_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ids_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // shared divider
   logic [NUM_W-1:0]  div_num_ff, div_num_in;
   logic [DEN_W-1:0]  div_rem_ff, div_rem_in;
   logic [DEN_W-1:0]  div_den_ff, div_den_in;
   logic [CNT_W-1:0]  div_cnt_ff, div_cnt_in;

   // datapath
   logic [MUL_W-1:0]  mul_ff, mul_in;
   logic [ANG_W-1:0]  ang_ff, ang_in;
   logic              neg_ff, neg_in;
   logic [TW-1:0]     c_ff, c_in;
   logic [TW-1:0]     h_ff, h_in;
   logic [TW-1:0]     h3_ff, h3_in;
   logic [TW-1:0]     lim_ff, lim_in;
   logic [TW-1:0]     da_ff, da_in;
   logic [TW-1:0]     ig_ff, ig_in;
   logic [TW-1:0]     a_ff, a_in;
   logic [TW-1:0]     lo_ff, lo_in;
   logic [TW-1:0]     hi_ff, hi_in;
   logic [TW-1:0]     res_da_ff, res_da_in;
   logic [TW-1:0]     res_ig_ff, res_ig_in;

   // ---------------------------------------------------------------------
   // item fields
   // ---------------------------------------------------------------------
   logic                      f_synced, f_enable, f_seq;
   logic [15:0]               f_pos;
   logic [19:0]               f_rate;
   logic [31:0]               f_calc, f_now, f_ev;
   logic [23:0]               f_dw, f_dev;
   logic [14:0]               f_adv;

   assign f_synced = item_ff[0];
   assign f_enable = item_ff[1];
   assign f_seq    = item_ff[2];
   assign f_pos    = item_ff[18:3];
   assign f_rate   = item_ff[38:19];
   assign f_calc   = item_ff[70:39];
   assign f_now    = item_ff[102:71];
   assign f_dw     = item_ff[126:103];
   assign f_adv    = item_ff[141:127];
   assign f_dev    = item_ff[165:142];
   assign f_ev     = item_ff[197:166];

   logic [TW-1:0]             calc_t, now_t, dw_t, dev_t, ev_t;
   logic [19:0]               rate1;
   logic [ids_pkg::CYC_DEG_BITS-1:0] cyc_deg;
   logic [DEN_W-1:0]          cyc_q;

   assign calc_t  = TW'(f_calc);
   assign now_t   = TW'(f_now);
   assign dw_t    = TW'(f_dw);
   assign dev_t   = TW'(f_dev);
   assign ev_t    = TW'(f_ev);
   assign rate1   = (f_rate == '0) ? 20'd1 : f_rate;
   assign cyc_deg = f_seq ? ids_pkg::CYCLE_DEG_SEQ : ids_pkg::CYCLE_DEG_WASTE;
   assign cyc_q   = DEN_W'(cyc_deg) << AFB;

   // ---------------------------------------------------------------------
   // divider step: restoring, one quotient bit per cycle
   // ---------------------------------------------------------------------
   logic [DEN_W:0]   div_part, div_diff;
   logic             div_ge;
   logic             div_done;

   assign div_part = {div_rem_ff, div_num_ff[NUM_W-1]};
   assign div_diff = div_part - {1'b0, div_den_ff};
   assign div_ge   = div_part >= {1'b0, div_den_ff};
   assign div_done = div_cnt_ff == '0;

   // ---------------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------------
   logic req_fire;

   assign req_tready = state_ff == ids_pkg::ST_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // state register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ids_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and scheduler state
   always_ff @(posedge clock) begin
      if (reset) begin
         tdc_ff       <= '0;
         tps_ff       <= ids_pkg::TPS_RESET;
         last_ff      <= '0;
         dwelling_ff  <= 1'b0;
         prev_seq_ff  <= 1'b0;
         dp_ff        <= 1'b0;
         ip_ff        <= 1'b0;
         fired_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         tdc_ff       <= tdc_in;
         tps_ff       <= tps_in;
         last_ff      <= last_in;
         dwelling_ff  <= dwelling_in;
         prev_seq_ff  <= prev_seq_in;
         dp_ff        <= dp_in;
         ip_ff        <= ip_in;
         fired_ff     <= fired_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_tdata;
         kind_ff <= req_tuser;
      end
      rsp_data_ff <= rsp_data_in;
      div_num_ff  <= div_num_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      mul_ff      <= mul_in;
      ang_ff      <= ang_in;
      neg_ff      <= neg_in;
      c_ff        <= c_in;
      h_ff        <= h_in;
      h3_ff       <= h3_in;
      lim_ff      <= lim_in;
      da_ff       <= da_in;
      ig_ff       <= ig_in;
      a_ff        <= a_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      res_da_ff   <= res_da_in;
      res_ig_ff   <= res_ig_in;
   end

   // ---------------------------------------------------------------------
   // sequencer and datapath
   // ---------------------------------------------------------------------
   logic signed [18:0] delta;
   logic [18:0]        delta_mag;
   logic [TW-1:0]      rem_t;
   logic [NUM_W-1:0]   q_c;
   logic [TW-1:0]      c_sat;
   logic [TW-1:0]      ig_calc;
   logic               hist_bad;
   logic [TW-1:0]      a_try;
   logic [TW-1:0]      da_fin;
   logic [TW-1:0]      lost_ig;

   always_comb begin
      state_in     = state_ff;
      tdc_in       = tdc_ff;
      tps_in       = tps_ff;
      last_in      = last_ff;
      dwelling_in  = dwelling_ff;
      prev_seq_in  = prev_seq_ff;
      dp_in        = dp_ff;
      ip_in        = ip_ff;
      fired_in     = fired_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      div_num_in   = {div_num_ff[NUM_W-2:0], div_ge};
      div_rem_in   = div_ge ? div_diff[DEN_W-1:0] : div_part[DEN_W-1:0];
      div_den_in   = div_den_ff;
      div_cnt_in   = div_done ? div_cnt_ff : div_cnt_ff - CNT_W'(1);
      if (div_done) begin
         div_num_in = div_num_ff;
         div_rem_in = div_rem_ff;
      end

      mul_in    = mul_ff;
      ang_in    = ang_ff;
      neg_in    = neg_ff;
      c_in      = c_ff;
      h_in      = h_ff;
      h3_in     = h3_ff;
      lim_in    = lim_ff;
      da_in     = da_ff;
      ig_in     = ig_ff;
      a_in      = a_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      res_da_in = res_da_ff;
      res_ig_in = res_ig_ff;

      delta     = $signed({3'b000, tdc_ff}) - {{4{f_adv[14]}}, f_adv}
                  - $signed({3'b000, f_pos});
      delta_mag = delta[18] ? 19'(-delta) : 19'(delta);
      rem_t     = TW'(div_rem_ff);
      q_c       = div_num_ff;
      if (q_c == '0) begin
         c_sat = TW'(1);
      end else if (q_c > NUM_W'(CYCLE_MAX)) begin
         c_sat = CYCLE_MAX;
      end else begin
         c_sat = TW'(q_c);
      end
      ig_calc  = TW'(div_num_ff) + calc_t - (c_ff << 1);
      hist_bad = (last_ff == '0) || t_less(last_ff + dw_t, calc_t - h3_ff)
                 || t_less(calc_t + h3_ff, last_ff);
      a_try    = dwelling_ff ? da_ff + h_ff : da_ff - h_ff;
      da_fin   = dwelling_ff ? a_ff - h_ff : a_ff + h_ff;
      lost_ig  = last_ff + dw_t;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            ids_pkg::CSR_TDC_ANGLE:        tdc_in = csr_data[15:0];
            ids_pkg::CSR_TICKS_PER_SECOND: tps_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ids_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = ids_pkg::ST_DEC;
            end
         end

         ids_pkg::ST_DEC: begin
            res_da_in = '0;
            res_ig_in = '0;
            state_in  = ids_pkg::ST_EMIT;
            case (kind_ff)
               ids_pkg::MODE_DWELL_FIRED: begin
                  if (dp_ff) begin
                     dp_in       = 1'b0;
                     fired_in    = ev_t;
                     dwelling_in = 1'b1;
                     if (!dwelling_ff) begin
                        last_in = (ev_t == '0) ? TW'(1) : ev_t;
                     end
                  end
               end
               ids_pkg::MODE_IGNITE_FIRED: begin
                  if (ip_ff) begin
                     ip_in       = 1'b0;
                     dwelling_in = 1'b0;
                  end
               end
               ids_pkg::MODE_SCHEDULE: begin
                  if (!f_synced || !f_enable) begin
                     // lost sync or disabled: fire any charge in progress
                     dp_in = 1'b0;
                     if (!ip_ff && dwelling_ff) begin
                        ip_in     = 1'b1;
                        last_in   = '0;
                        res_ig_in = lost_ig;
                     end
                  end else begin
                     if (prev_seq_ff != f_seq) begin
                        dp_in       = 1'b0;
                        last_in     = '0;
                        prev_seq_in = f_seq;
                     end
                     mul_in     = tps_ff * ANG_W'(cyc_deg);
                     neg_in     = delta[18];
                     div_num_in = NUM_W'(delta_mag[K_MOD-1:0]) << (NUM_W - K_MOD);
                     div_rem_in = '0;
                     div_den_in = cyc_q;
                     div_cnt_in = CNT_W'(K_MOD);
                     state_in   = ids_pkg::ST_MOD;
                  end
               end
               default: ;
            endcase
         end

         ids_pkg::ST_MOD: begin
            if (div_done) begin
               // C remainder truncates toward zero; bring into [0, cycle)
               if (neg_ff && div_rem_ff != '0) begin
                  ang_in = ANG_W'(cyc_q - div_rem_ff);
               end else begin
                  ang_in = ANG_W'(div_rem_ff);
               end
               div_num_in = NUM_W'(mul_ff) << (NUM_W - K_CYC);
               div_rem_in = '0;
               div_den_in = DEN_W'(rate1);
               div_cnt_in = CNT_W'(K_CYC);
               state_in   = ids_pkg::ST_DIVC;
            end
         end

         ids_pkg::ST_DIVC: begin
            mul_in = tps_ff * ang_ff;
            if (div_done) begin
               c_in       = c_sat;
               div_num_in = NUM_W'(mul_ff) << (NUM_W - K_ANG);
               div_rem_in = '0;
               div_den_in = DEN_W'(rate1) << AFB;
               div_cnt_in = CNT_W'(K_ANG);
               state_in   = ids_pkg::ST_DIVA;
            end
         end

         ids_pkg::ST_DIVA: begin
            h_in   = c_ff >> 1;
            h3_in  = (c_ff >> 1) + ((c_ff >> 1) << 1);
            lim_in = now_t - c_ff;
            if (div_done) begin
               da_in    = ig_calc - dw_t;
               state_in = ids_pkg::ST_CHK;
            end
         end

         ids_pkg::ST_CHK: begin
            state_in = ids_pkg::ST_ADV;
            if (!dp_ff && hist_bad) begin
               if (t_less(da_ff, lim_ff) || da_ff == lim_ff) begin
                  div_num_in = NUM_W'(lim_ff - da_ff) << (NUM_W - K_TICK);
                  div_rem_in = '0;
                  div_den_in = DEN_W'(c_ff);
                  div_cnt_in = CNT_W'(K_TICK);
                  state_in   = ids_pkg::ST_AL1;
               end else begin
                  last_in = da_ff;
               end
            end
         end

         ids_pkg::ST_AL1: begin
            if (div_done) begin
               // first cycle step strictly past now - cycle
               last_in  = lim_ff - rem_t + c_ff;
               state_in = ids_pkg::ST_ADV;
            end
         end

         ids_pkg::ST_ADV: begin
            a_in     = a_try;
            state_in = ids_pkg::ST_FIN;
            if (t_less(a_try, last_ff)) begin
               div_num_in = NUM_W'(last_ff - a_try) << (NUM_W - K_TICK);
               div_rem_in = '0;
               div_den_in = DEN_W'(c_ff);
               div_cnt_in = CNT_W'(K_TICK);
               state_in   = ids_pkg::ST_AL2;
            end
         end

         ids_pkg::ST_AL2: begin
            if (div_done) begin
               // round the gap up to whole cycles
               a_in     = last_ff + ((rem_t != '0) ? c_ff - rem_t : '0);
               state_in = ids_pkg::ST_FIN;
            end
         end

         ids_pkg::ST_FIN: begin
            da_in    = da_fin;
            ig_in    = da_fin + dw_t;
            lo_in    = fired_ff + dw_t - dev_t;
            hi_in    = fired_ff + dw_t + dev_t;
            state_in = ids_pkg::ST_FIN2;
         end

         ids_pkg::ST_FIN2: begin
            dp_in = 1'b1;
            ip_in = 1'b1;
            if (!dwelling_ff) begin
               res_da_in = da_ff;
               res_ig_in = ig_ff;
            end else begin
               // coil already charging: keep spark near fired dwell + dwell
               res_da_in = da_ff + c_ff;
               if (t_less(ig_ff, lo_ff)) begin
                  res_ig_in = lo_ff;
               end else if (t_less(hi_ff, ig_ff)) begin
                  res_ig_in = hi_ff;
               end else begin
                  res_ig_in = ig_ff;
               end
            end
            state_in = ids_pkg::ST_EMIT;
         end

         ids_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b00000, dwelling_ff, ip_ff, dp_ff,
                               32'(res_ig_ff), 32'(res_da_ff)};
               state_in     = ids_pkg::ST_IDLE;
            end
         end

         default: state_in = ids_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      !div_done |-> !req_tready)
      else $error("divider busy while accepting a beat");

   a_cycle_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ids_pkg::ST_DIVA |-> (c_ff != '0 && !c_ff[TW-1]))
      else $error("cycle ticks outside saturation range");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ids_pkg::ST_AL2 && div_done) |-> div_rem_ff < div_den_ff)
      else $error("divider remainder not below divisor");

endmodule
